// ----- sv/fna_pkg.sv -----
// Shared types and constants for the free number allocator.
package fna_pkg;

  localparam int FUNC_W = 2;
  localparam int NUM_W  = 10;
  localparam int CFG_W  = 11;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_req;  // capture request, restart scan
    logic rd_look;   // read word holding the request number
    logic rd_scan;   // read next word of the scan
    logic commit;    // write back, update count, load result
    logic clr_wr;    // clearing pass write
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic free_zero;  // no free number below the active count
    logic found;      // scanned word holds a free bit
    logic clr_last;   // clearing pass at last word
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// ----- sv/fna_ctrl.sv -----
// Sequencing state machine for the free number allocator.
module fna_ctrl
  import fna_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic              cfg_we_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o,
  output logic              in_stall_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          priority if (func_i == FUNC_GET && !sts_i.free_zero) begin
            state_d = ST_SCAN;
          end else if (func_i == FUNC_CHECK || func_i == FUNC_RELEASE) begin
            state_d = ST_LOOK;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_LOOK: begin
        cmd_o.rd_look = 1'b1;
        state_d       = ST_FIN;
      end
      ST_SCAN: begin
        cmd_o.rd_scan = !sts_i.found;
        if (sts_i.found) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // a register write restarts the clearing pass
    if (cfg_we_i) state_d = ST_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && !cfg_we_i) |=> !in_stall_o || cfg_we_i)
    else $error("commit did not return to idle");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> in_stall_o)
    else $error("transfer accepted during clearing pass");

  a_scan_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_req && func_i == FUNC_GET) |=>
      (state_q == ST_SCAN || state_q == ST_FIN || state_q == ST_CLEAR))
    else $error("get request took a wrong path");

endmodule

// ----- sv/fna_dpath.sv -----
// Bitmap memory, scan logic, free count and result register.
module fna_dpath
  import fna_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [NUM_W-1:0]  number_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              out_stall_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  output logic [NUM_W-1:0]  granted_o,
  output logic              none_free_o,
  output logic              is_free_o
);

  localparam int WORDS = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NW0   = (IDX_W > NUM_W) ? IDX_W : NUM_W;
  localparam int NW    = (NW0 > AW + BIT_W) ? NW0 : AW + BIT_W;
  localparam int MW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int KW    = (NW > CW) ? NW : CW;
  localparam int N_RST = (CAPACITY < 1024) ? CAPACITY : 1024;
  localparam int NBYTE = WORD_W / 8;

  logic [WORD_W-1:0] mem [WORDS];

  logic [WORD_W-1:0] rd_data_q;
  logic [AW-1:0]     dat_addr_q;
  logic              rd_valid_q;
  logic [AW-1:0]     scan_addr_q;
  logic [AW-1:0]     clr_addr_q;
  logic [FUNC_W-1:0] func_q;
  logic [NUM_W-1:0]  number_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     free_count_q;
  logic              out_valid_q;
  logic [NUM_W-1:0]  granted_q;
  logic              none_free_q;
  logic              is_free_q;

  logic [NW-1:0]     num_ext;
  logic [AW-1:0]     look_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic              in_range;
  logic              free_zero;
  logic              any_zero;
  logic [BIT_W-1:0]  ff_pos;
  logic [AW+14:0]    gidx;
  logic [BIT_W-1:0]  bit_sel;
  logic              cur_bit;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [CW-1:0]     n_new;
  logic              out_free;

  logic [NUM_W-1:0]  granted_d;
  logic              none_free_d;
  logic              is_free_d;
  logic              wb_en;
  logic              cnt_dec;
  logic              cnt_inc;

  assign num_ext   = NW'(number_q);
  assign look_addr = num_ext[BIT_W +: AW];
  assign rd_addr   = cmd_i.rd_look ? look_addr : scan_addr_q;
  assign rd_en     = cmd_i.rd_look || cmd_i.rd_scan;
  assign in_range  = KW'(number_q) < KW'(n_q);
  assign free_zero = (free_count_q == '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  // lowest zero bit: first zero inside each byte, then first byte with one
  always_comb begin
    logic [NBYTE-1:0] byte_hit;
    logic [2:0]       byte_pos [NBYTE];
    byte_hit = '0;
    ff_pos   = '0;
    for (int b = 0; b < NBYTE; b++) begin
      byte_hit[b] = ~&rd_data_q[8*b +: 8];
      byte_pos[b] = '0;
      for (int i = 7; i >= 0; i--) begin
        if (!rd_data_q[8*b + i]) byte_pos[b] = 3'(i);
      end
    end
    for (int b = NBYTE - 1; b >= 0; b--) begin
      if (byte_hit[b]) ff_pos = BIT_W'({b[1:0], byte_pos[b]});
    end
    any_zero = |byte_hit;
  end

  assign gidx    = (AW + 15)'({dat_addr_q, ff_pos});
  assign bit_sel = (func_q == FUNC_GET) ? ff_pos : number_q[BIT_W-1:0];
  assign cur_bit = rd_data_q[bit_sel];

  always_comb begin
    granted_d   = '0;
    none_free_d = 1'b0;
    is_free_d   = 1'b0;
    wb_en       = 1'b0;
    cnt_dec     = 1'b0;
    cnt_inc     = 1'b0;
    unique case (func_q)
      FUNC_GET: begin
        if (free_zero) begin
          none_free_d = 1'b1;
        end else begin
          granted_d = gidx[NUM_W-1:0];
          wb_en     = 1'b1;
          cnt_dec   = 1'b1;
        end
      end
      FUNC_CHECK: is_free_d = !in_range || !cur_bit;
      FUNC_RELEASE: begin
        if (in_range && cur_bit) begin
          wb_en   = 1'b1;
          cnt_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.commit && wb_en) begin
      mem_we    = 1'b1;
      mem_waddr = dat_addr_q;
      mem_wdata = rd_data_q;
      mem_wdata[bit_sel] = (func_q == FUNC_GET);
    end
  end

  assign n_new = (MW'(cfg_wdata_i) > MW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cfg_wdata_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rd_data_q  <= mem[rd_addr];
      dat_addr_q <= rd_addr;
    end
    if (cmd_i.load_req) begin
      func_q   <= func_i;
      number_q <= number_i;
    end
    if (cmd_i.commit) begin
      granted_q   <= granted_d;
      none_free_q <= none_free_d;
      is_free_q   <= is_free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      scan_addr_q  <= '0;
      clr_addr_q   <= '0;
      n_q          <= CW'(N_RST);
      free_count_q <= CW'(N_RST);
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        rd_valid_q  <= 1'b0;
        scan_addr_q <= '0;
      end else if (rd_en) begin
        rd_valid_q <= 1'b1;
        if (cmd_i.rd_scan) scan_addr_q <= scan_addr_q + 1'b1;
      end
      if (cfg_we_i) begin
        clr_addr_q   <= '0;
        n_q          <= n_new;
        free_count_q <= n_new;
      end else begin
        if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
        if (cmd_i.commit && cnt_dec) free_count_q <= free_count_q - 1'b1;
        if (cmd_i.commit && cnt_inc) free_count_q <= free_count_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.free_zero = free_zero;
  assign sts_o.found     = rd_valid_q && any_zero;
  assign sts_o.clr_last  = (clr_addr_q == AW'(WORDS - 1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign none_free_o = none_free_q;
  assign is_free_o   = is_free_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= n_q)
    else $error("free count above active count");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_wr && cmd_i.commit))
    else $error("clearing write and commit together");

  a_commit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result register overwritten");

  a_grant_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && func_q == FUNC_GET && !free_zero) |-> (rd_valid_q && any_zero))
    else $error("grant without a free bit");

endmodule

// ----- sv/free_number_allocator.sv -----
// Top level of the free number allocator: controller plus bitmap datapath.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) with
// func_i (0 get, 1 check, 2 release) and number_i. Every request not cut
// off by a cfg write gives exactly one result on the output channel
// (out_valid_o / out_stall_i): granted_o, none_free_o and is_free_o. Get
// always hands out the lowest free number below the active count.
// The allocation bitmap sits in a memory of 32-bit words with one read
// and one write port. Check and release read one word in the look state
// and register the result in the final state; the next request is taken
// only once back in idle. Get scans one word per cycle from word 0 up to
// the word that holds the grant, then registers the result in the final
// state; get with nothing free goes straight to the final state. Reset,
// and every write of cfg_wdata_i (max_numbers), starts a clearing pass
// over every word of the bitmap during which in_stall_o is high. The
// result register holds one result; while the receiver stalls, the next
// request is still taken and worked on, and waits at its final step
// until the register frees up.
module free_number_allocator
  import fna_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [NUM_W-1:0]  number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NUM_W-1:0]  granted_o,
  output logic              none_free_o,
  output logic              is_free_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  fna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  fna_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .number_i    (number_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .granted_o   (granted_o),
    .none_free_o (none_free_o),
    .is_free_o   (is_free_o)
  );

endmodule
